/* hw/rtl/vrt_pkg.sv */
// Shared constants and pair tables for the voxel ray traversal block.
// Used by vrt_front, vrt_walk, vrt_fifo and voxel_ray_traversal_3d.
package vrt_pkg;

    localparam int MAX_CELLS_DEF  = 64;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int INT_BITS_DEF   = 16;
    localparam int DEN_W          = 34;   // |direction| in LSBs
    localparam int HALF_W         = 17;   // den is multiplied in two halves
    localparam int FIFO_DEPTH     = 2;
    localparam int NUM_PAIRS      = 6;

    // Ordered axis pairs (a,b); the product for pair p is num_a * den_b.
    function automatic logic [1:0] pair_a(input logic [2:0] p);
        logic [1:0] r;
        unique case (p)
            3'd0, 3'd2: r = 2'd0;
            3'd1, 3'd4: r = 2'd1;
            default:    r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] pair_b(input logic [2:0] p);
        logic [1:0] r;
        unique case (p)
            3'd0:       r = 2'd1;
            3'd1, 3'd3: r = 2'd0;
            3'd5:       r = 2'd1;
            default:    r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] pair_idx(input logic [1:0] a, input logic [1:0] b);
        logic [2:0] r;
        r = 3'd5;
        for (int p = 0; p < NUM_PAIRS; p++) begin
            if (pair_a(3'(p)) == a && pair_b(3'(p)) == b) begin
                r = 3'(p);
            end
        end
        return r;
    endfunction

endpackage

/* hw/rtl/vrt_fifo.sv */
// Small job queue between the setup front and the walk back end.
// Depends on vrt_pkg for the default depth.
module vrt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = vrt_pkg::FIFO_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wptr_reg, rptr_reg;
    logic [CNW-1:0]   count_reg;

    assign full  = (count_reg == CNW'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/vrt_front.sv */
// Front end: takes a segment, derives per-axis DDA setup and the six
// cross products of tMax numerators and denominators. Uses vrt_pkg.
module vrt_front #(
    parameter int FRAC_BITS = vrt_pkg::FRAC_BITS_DEF,
    parameter int INT_BITS  = vrt_pkg::INT_BITS_DEF,
    parameter int CW        = 41 - FRAC_BITS,
    parameter int JW        = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [31:0]   start_x,
    input  logic signed [31:0]   start_y,
    input  logic signed [31:0]   start_z,
    input  logic signed [31:0]   end_x,
    input  logic signed [31:0]   end_y,
    input  logic signed [31:0]   end_z,
    output logic                 busy,
    input  logic                 full,
    output logic                 push,
    output logic [JW-1:0]        job
);

    localparam int DW   = vrt_pkg::DEN_W;
    localparam int HW   = vrt_pkg::HALF_W;
    localparam int NW   = FRAC_BITS + 1;
    localparam int MW   = NW + HW;
    localparam int PRW  = FRAC_BITS + 41;
    localparam int AXW  = CW + INT_BITS + 2 + DW;
    localparam int NP   = vrt_pkg::NUM_PAIRS;
    localparam int MSTEPS = 2 * NP;
    localparam logic [31:0] FMASK = (32'd1 << FRAC_BITS) - 32'd1;

    typedef enum logic [1:0] {F_IDLE, F_SETUP, F_MUL, F_PUSH} fstate_t;

    fstate_t           state_reg;
    logic [3:0]        cnt_reg;
    logic [3:0]        tag_reg;
    logic [31:0]       s_reg [3];
    logic [31:0]       e_reg [3];
    logic [NW-1:0]     num_reg [3];
    logic [DW-1:0]     den_reg [3];
    logic              dz_reg [3];
    logic              neg_reg [3];
    logic [CW-1:0]     cell_reg [3];
    logic [INT_BITS-1:0] idx_reg [3];
    logic [PRW-1:0]    prod_reg [NP];
    logic [MW-1:0]     mul_reg;

    // setup arithmetic
    logic [NW-1:0]     num_next [3];
    logic [DW-1:0]     den_next [3];
    logic              dz_next [3];
    logic              neg_next [3];
    logic [CW-1:0]     cell_next [3];
    logic [INT_BITS-1:0] idx_next [3];

    always_comb
    begin
        logic [31:0]          ebase;
        logic [FRAC_BITS-1:0] efrac;
        logic [FRAC_BITS-1:0] erel;
        logic [FRAC_BITS-1:0] sfrac;
        logic signed [33:0]   srel;
        logic signed [34:0]   dir;
        logic signed [33:0]   cfull;
        logic signed [34:0]   isum;
        logic [34:0]          ndir;
        for (int i = 0; i < 3; i++)
        begin
            efrac = e_reg[i][FRAC_BITS-1:0];
            ebase = e_reg[i] & ~FMASK;
            srel  = $signed({{2{s_reg[i][31]}}, s_reg[i]})
                  - $signed({{2{ebase[31]}}, ebase});
            erel  = (efrac == '0) ? FRAC_BITS'(1) : efrac;
            dir   = $signed({{(35 - FRAC_BITS){1'b0}}, erel}) - $signed({srel[33], srel});
            sfrac = srel[FRAC_BITS-1:0];
            ndir  = 35'(-dir);
            cfull = srel >>> FRAC_BITS;
            isum  = $signed({cfull[33], cfull})
                  + ($signed({{3{ebase[31]}}, ebase[31:0]}) >>> FRAC_BITS);
            neg_next[i]  = dir[34];
            dz_next[i]   = (dir == '0);
            den_next[i]  = dir[34] ? ndir[DW-1:0] : dir[DW-1:0];
            if (dir[34])
            begin
                num_next[i] = {1'b0, sfrac};
            end
            else if (dir == '0)
            begin
                num_next[i] = '0;
            end
            else
            begin
                num_next[i] = (NW'(1) << FRAC_BITS) - {1'b0, sfrac};
            end
            cell_next[i] = cfull[CW-1:0];
            idx_next[i]  = isum[INT_BITS-1:0];
        end
    end

    // one shared multiplier: pair cnt[3:1], den half cnt[0]
    logic [2:0]    mp;
    logic [1:0]    ma, mb;
    logic [HW-1:0] mhalf;
    logic [DW:0]   dext;
    assign mp    = cnt_reg[3:1];
    assign ma    = vrt_pkg::pair_a(mp);
    assign mb    = vrt_pkg::pair_b(mp);
    assign dext  = {1'b0, den_reg[mb]};
    assign mhalf = cnt_reg[0] ? dext[2*HW-1:HW] : dext[HW-1:0];

    assign busy = (state_reg != F_IDLE);
    assign push = (state_reg == F_PUSH) && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= F_SETUP;
                    end
                end
                F_SETUP:
                begin
                    cnt_reg   <= '0;
                    state_reg <= F_MUL;
                end
                F_MUL:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 4'(MSTEPS))
                    begin
                        state_reg <= F_PUSH;
                    end
                end
                F_PUSH:
                begin
                    if (!full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && start)
        begin
            s_reg[0] <= start_x;
            s_reg[1] <= start_y;
            s_reg[2] <= start_z;
            e_reg[0] <= end_x;
            e_reg[1] <= end_y;
            e_reg[2] <= end_z;
        end
        if (state_reg == F_SETUP)
        begin
            for (int i = 0; i < 3; i++)
            begin
                num_reg[i]  <= num_next[i];
                den_reg[i]  <= den_next[i];
                dz_reg[i]   <= dz_next[i];
                neg_reg[i]  <= neg_next[i];
                cell_reg[i] <= cell_next[i];
                idx_reg[i]  <= idx_next[i];
            end
            for (int p = 0; p < NP; p++)
            begin
                prod_reg[p] <= '0;
            end
        end
        if (state_reg == F_MUL)
        begin
            if (cnt_reg < 4'(MSTEPS))
            begin
                mul_reg <= num_reg[ma] * mhalf;
                tag_reg <= cnt_reg;
            end
            if (cnt_reg != '0)
            begin
                // accumulate the partial product of the previous cycle
                prod_reg[tag_reg[3:1]] <= prod_reg[tag_reg[3:1]]
                    + (tag_reg[0] ? (PRW'(mul_reg) << HW) : PRW'(mul_reg));
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            job[i*AXW +: AXW] = {cell_reg[i], idx_reg[i], neg_reg[i], dz_reg[i], den_reg[i]};
        end
        for (int p = 0; p < NP; p++)
        begin
            job[3*AXW + p*PRW +: PRW] = prod_reg[p];
        end
    end

endmodule

/* hw/rtl/vrt_walk.sv */
// Back end: walks the DDA one voxel per cycle from a queued job.
// Depends on vrt_pkg for the pair tables.
module vrt_walk #(
    parameter int MAX_CELLS = vrt_pkg::MAX_CELLS_DEF,
    parameter int FRAC_BITS = vrt_pkg::FRAC_BITS_DEF,
    parameter int INT_BITS  = vrt_pkg::INT_BITS_DEF,
    parameter int CW        = 41 - FRAC_BITS,
    parameter int JW        = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [JW-1:0]       job,
    input  logic                empty,
    output logic                pop,
    output logic                valid,
    output logic signed [15:0]  voxel_x,
    output logic signed [15:0]  voxel_y,
    output logic signed [15:0]  voxel_z,
    output logic                last,
    output logic                truncated
);

    localparam int DW  = vrt_pkg::DEN_W;
    localparam int PRW = FRAC_BITS + 41;
    localparam int AXW = CW + INT_BITS + 2 + DW;
    localparam int NP  = vrt_pkg::NUM_PAIRS;
    localparam int CNW = $clog2(MAX_CELLS);

    logic                active_reg;
    logic [CNW-1:0]      cnt_reg;
    logic [CW-1:0]       cell_reg [3];
    logic [INT_BITS-1:0] idx_reg [3];
    logic [DW-1:0]       den_reg [3];
    logic                dz_reg [3];
    logic                neg_reg [3];
    logic [PRW-1:0]      prod_reg [NP];
    logic                valid_reg, last_reg, trunc_reg;
    logic [15:0]         vox_reg [3];

    function automatic logic t_less(input logic [PRW-1:0] pab, input logic [PRW-1:0] pba,
                                    input logic dza, input logic dzb);
        logic r;
        r = !dza && (dzb || (pab < pba));
        return r;
    endfunction

    logic l01, l02, l12;
    logic [1:0] ax;
    logic at_end, cap;

    assign l01 = t_less(prod_reg[vrt_pkg::pair_idx(2'd0, 2'd1)],
                        prod_reg[vrt_pkg::pair_idx(2'd1, 2'd0)], dz_reg[0], dz_reg[1]);
    assign l02 = t_less(prod_reg[vrt_pkg::pair_idx(2'd0, 2'd2)],
                        prod_reg[vrt_pkg::pair_idx(2'd2, 2'd0)], dz_reg[0], dz_reg[2]);
    assign l12 = t_less(prod_reg[vrt_pkg::pair_idx(2'd1, 2'd2)],
                        prod_reg[vrt_pkg::pair_idx(2'd2, 2'd1)], dz_reg[1], dz_reg[2]);
    assign ax  = l01 ? (l02 ? 2'd0 : 2'd2) : (l12 ? 2'd1 : 2'd2);

    assign at_end = (cell_reg[0] == '0) && (cell_reg[1] == '0) && (cell_reg[2] == '0);
    assign cap    = (cnt_reg == CNW'(MAX_CELLS - 1));
    assign pop    = !active_reg && !empty;

    assign valid     = valid_reg;
    assign last      = last_reg;
    assign truncated = trunc_reg;
    assign voxel_x   = vox_reg[0];
    assign voxel_y   = vox_reg[1];
    assign voxel_z   = vox_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            valid_reg <= active_reg;
            if (pop)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= '0;
            end
            else if (active_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (at_end || cap)
                begin
                    active_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        logic [31:0] ext;
        if (pop)
        begin
            for (int i = 0; i < 3; i++)
            begin
                {cell_reg[i], idx_reg[i], neg_reg[i], dz_reg[i], den_reg[i]} <= job[i*AXW +: AXW];
            end
            for (int p = 0; p < NP; p++)
            begin
                prod_reg[p] <= job[3*AXW + p*PRW +: PRW];
            end
        end
        else if (active_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ext = {{(32 - INT_BITS){idx_reg[i][INT_BITS-1]}}, idx_reg[i]};
                vox_reg[i] <= ext[15:0];
            end
            last_reg  <= at_end || cap;
            trunc_reg <= !at_end && cap;
            if (!at_end && !cap && !dz_reg[ax])
            begin
                cell_reg[ax] <= neg_reg[ax] ? cell_reg[ax] - 1'b1 : cell_reg[ax] + 1'b1;
                idx_reg[ax]  <= neg_reg[ax] ? idx_reg[ax] - 1'b1 : idx_reg[ax] + 1'b1;
                // num_ax grows by one voxel: every num_ax * den_b grows by den_b << FRAC_BITS
                for (int p = 0; p < NP; p++)
                begin
                    if (vrt_pkg::pair_a(3'(p)) == ax)
                    begin
                        prod_reg[p] <= prod_reg[p]
                            + (PRW'(den_reg[vrt_pkg::pair_b(3'(p))]) << FRAC_BITS);
                    end
                end
            end
        end
    end

endmodule

/* hw/rtl/voxel_ray_traversal_3d.sv */
// Top level of the 3D voxel ray traversal (exact fixed-point DDA).
// Depends on vrt_pkg, vrt_front, vrt_fifo and vrt_walk.
//
//  channel   ports                                  transfer when
//  input     start, start_x..end_z / busy           start && !busy
//  result    valid, voxel_x/y/z, last, truncated    valid (one cycle each)
//
// Setup per segment: capture, per-axis setup, then twelve partial products
// through one shared multiplier plus a drain step, then the push of the job.
// The walk then emits one voxel per cycle, up to MAX_CELLS per segment.
// A two-entry job queue lets the front set up the next segment during a walk.
// Reset clears control only; the receiver cannot stall, results always flow.
module voxel_ray_traversal_3d #(
    parameter int MAX_CELLS = vrt_pkg::MAX_CELLS_DEF,
    parameter int FRAC_BITS = vrt_pkg::FRAC_BITS_DEF,
    parameter int INT_BITS  = vrt_pkg::INT_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] start_x,
    input  logic signed [31:0] start_y,
    input  logic signed [31:0] start_z,
    input  logic signed [31:0] end_x,
    input  logic signed [31:0] end_y,
    input  logic signed [31:0] end_z,
    output logic               valid,
    output logic signed [15:0] voxel_x,
    output logic signed [15:0] voxel_y,
    output logic signed [15:0] voxel_z,
    output logic               last,
    output logic               truncated
);

    localparam int CW  = 41 - FRAC_BITS;
    localparam int AXW = CW + INT_BITS + 2 + vrt_pkg::DEN_W;
    localparam int PRW = FRAC_BITS + 41;
    localparam int JW  = 3 * AXW + vrt_pkg::NUM_PAIRS * PRW;

    logic          push, pop, full, empty;
    logic [JW-1:0] job_in, job_out;

    vrt_front #(
        .FRAC_BITS (FRAC_BITS),
        .INT_BITS  (INT_BITS),
        .CW        (CW),
        .JW        (JW)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .start_x (start_x),
        .start_y (start_y),
        .start_z (start_z),
        .end_x   (end_x),
        .end_y   (end_y),
        .end_z   (end_z),
        .busy    (busy),
        .full    (full),
        .push    (push),
        .job     (job_in)
    );

    vrt_fifo #(
        .WIDTH (JW),
        .DEPTH (vrt_pkg::FIFO_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (job_in),
        .pop   (pop),
        .rdata (job_out),
        .full  (full),
        .empty (empty)
    );

    vrt_walk #(
        .MAX_CELLS (MAX_CELLS),
        .FRAC_BITS (FRAC_BITS),
        .INT_BITS  (INT_BITS),
        .CW        (CW),
        .JW        (JW)
    ) u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job_out),
        .empty     (empty),
        .pop       (pop),
        .valid     (valid),
        .voxel_x   (voxel_x),
        .voxel_y   (voxel_y),
        .voxel_z   (voxel_z),
        .last      (last),
        .truncated (truncated)
    );

    // voxels of one segment come out back to back
    a_walk_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !last |=> valid)
        else $error("voxel stream broke before last");

    a_trunc_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && truncated |-> last)
        else $error("truncated flag without last");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("job queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("job queue underflow");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("front not busy after transfer");

endmodule
